[rtl/tcg_pkg.sv]
// Shared types, codes and tables of the texture coordinate generator.
package tcg_pkg;

  // Input item: vertex position in signed Q16.16
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_vertex;
  } in_item_t;

  // Result item: texture coordinates in signed Q16.16
  typedef struct packed {
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               last_out;
  } out_item_t;

  // Global pipeline control between stages
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  // Mapping modes
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_PLANE    = 3'd1;
  localparam logic [2:0] MODE_SPHERE   = 3'd2;
  localparam logic [2:0] MODE_CYLINDER = 3'd3;
  localparam logic [2:0] MODE_DISC     = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_PAIR0 = 3'd1;
  localparam logic [2:0] REG_PAIR5 = 3'd6;

  // Square root pipeline: one result bit per stage
  localparam int SQRT_STAGES = 32;

  // Angle unit datapath width and normalization target width
  localparam int CW = 44;
  localparam int MW = 40;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

[rtl/tcg_xform.sv]
// Three-stage affine transform of a vertex by the 3x4 matrix.
module tcg_xform import tcg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctl_t          ctl_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               last_i,
  input  logic [63:0]        pair_i [6],
  output logic               vld_o,
  output logic               last_o,
  output logic signed [31:0] x_o,
  output logic signed [31:0] y_o,
  output logic signed [31:0] z_o
);

  logic signed [31:0] coef [12];
  logic signed [63:0] prod_q [9];
  logic signed [49:0] sum_q [3];
  logic signed [31:0] res_q [3];
  logic [2:0]         vld_q;
  logic [2:0]         last_q;

  // Split the register pairs into coefficients, high half first
  for (genvar k = 0; k < 6; k++) begin : g_coef
    assign coef[2*k]   = pair_i[k][63:32];
    assign coef[2*k+1] = pair_i[k][31:0];
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    logic signed [65:0] sum3;
    logic signed [50:0] tsum;

    // Stage 1: products of the row
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        prod_q[3*j]   <= coef[j]   * pos_x_i;
        prod_q[3*j+1] <= coef[3+j] * pos_y_i;
        prod_q[3*j+2] <= coef[6+j] * pos_z_i;
      end
    end

    // Stage 2: exact sum floored to Q16.16
    assign sum3 = 66'(prod_q[3*j]) + 66'(prod_q[3*j+1]) + 66'(prod_q[3*j+2]);
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        sum_q[j] <= sum3[65:16];
      end
    end

    // Stage 3: add translation and saturate
    assign tsum = 51'(sum_q[j]) + 51'(coef[9+j]);
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        if (tsum > 51'sd2147483647) begin
          res_q[j] <= 32'sh7FFFFFFF;
        end else if (tsum < -51'sd2147483648) begin
          res_q[j] <= 32'sh80000000;
        end else begin
          res_q[j] <= tsum[31:0];
        end
      end
    end
  end

  // Advance valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[1:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      last_q <= {last_q[1:0], last_i};
    end
  end

  assign vld_o  = vld_q[2];
  assign last_o = last_q[2];
  assign x_o    = res_q[0];
  assign y_o    = res_q[1];
  assign z_o    = res_q[2];

endmodule

[rtl/tcg_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module tcg_isqrt import tcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pipe_ctl_t   ctl_i,
  input  logic [63:0] n_i,
  output logic        vld_o,
  output logic [31:0] root_o
);

  logic [63:0]            n_q [SQRT_STAGES-1];
  logic [63:0]            r_q [SQRT_STAGES];
  logic [SQRT_STAGES-1:0] vld_q;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] n_in;
    logic [63:0] r_in;
    logic        v_in;
    logic [63:0] rb;
    logic        fit;

    if (k == 0) begin : g_first
      assign n_in = n_i;
      assign r_in = '0;
      assign v_in = ctl_i.vld;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = vld_q[k-1];
    end

    // Try the next result bit
    assign rb  = r_in + BIT;
    assign fit = (n_in >= rb);

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        r_q[k] <= fit ? ((r_in >> 1) + BIT) : (r_in >> 1);
      end
    end

    if (k < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          n_q[k] <= fit ? (n_in - rb) : n_in;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_q[k] <= v_in;
      end
    end
  end

  assign vld_o  = vld_q[SQRT_STAGES-1];
  assign root_o = r_q[SQRT_STAGES-1][31:0];

endmodule

[rtl/tcg_cordic.sv]
// Pipelined vectoring angle unit: fold, two normalize stages, one stage per step.
module tcg_cordic import tcg_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctl_t          ctl_i,
  input  logic signed [33:0] py_i,
  input  logic signed [33:0] px_i,
  output logic               vld_o,
  output logic [15:0]        ang_o
);

  logic signed [CW-1:0] pxe, pye, fx, fy, ay;
  logic                 neg;
  logic signed [CW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [MW-1:0]        m0_q, m1_q;
  logic [31:0]          a0_q, a1_q, a2_q;
  logic [2:0]           z_s_q, v_s_q;
  logic signed [CW-1:0] x1_d, y1_d, x2_d, y2_d;
  logic [MW-1:0]        m1_d, m2_d;
  logic signed [CW-1:0] xi_q [ITER];
  logic signed [CW-1:0] yi_q [ITER];
  logic [31:0]          acc_q [ITER];
  logic [ITER-1:0]      zi_q, vi_q;
  logic [31:0]          rnd;

  // Fold the vector into the right half plane
  assign pxe = CW'(px_i);
  assign pye = CW'(py_i);
  assign neg = pxe < 0;
  assign fx  = neg ? -pxe : pxe;
  assign fy  = neg ? -pye : pye;
  assign ay  = (fy < 0) ? -fy : fy;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x0_q <= fx;
      y0_q <= fy;
      m0_q <= (fx > ay) ? MW'(fx) : MW'(ay);
      a0_q <= neg ? 32'h80000000 : 32'h0;
    end
  end

  // Normalize coarse shifts
  always_comb begin
    x1_d = x0_q;
    y1_d = y0_q;
    m1_d = m0_q;
    for (int j = 0; j < 3; j++) begin
      if (m1_d < (MW'(1) << (MW - (32 >> j)))) begin
        m1_d = m1_d << (32 >> j);
        x1_d = x1_d <<< (32 >> j);
        y1_d = y1_d <<< (32 >> j);
      end
    end
  end

  // Normalize fine shifts
  always_comb begin
    x2_d = x1_q;
    y2_d = y1_q;
    m2_d = m1_q;
    for (int j = 0; j < 3; j++) begin
      if (m2_d < (MW'(1) << (MW - (4 >> j)))) begin
        m2_d = m2_d << (4 >> j);
        x2_d = x2_d <<< (4 >> j);
        y2_d = y2_d <<< (4 >> j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      x1_q <= x1_d;
      y1_q <= y1_d;
      m1_q <= m1_d;
      a1_q <= a0_q;
      x2_q <= x2_d;
      y2_q <= y2_d;
      a2_q <= a1_q;
      z_s_q <= {z_s_q[1:0], (px_i == '0) && (py_i == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s_q <= '0;
    end else if (ctl_i.en) begin
      v_s_q <= {v_s_q[1:0], ctl_i.vld};
    end
  end

  // Vectoring steps, one per stage
  for (genvar i = 0; i < ITER; i++) begin : g_step
    logic signed [CW-1:0] x_in, y_in;
    logic [31:0]          a_in;
    logic                 z_in, v_in, up;

    if (i == 0) begin : g_first
      assign x_in = x2_q;
      assign y_in = y2_q;
      assign a_in = a2_q;
      assign z_in = z_s_q[2];
      assign v_in = v_s_q[2];
    end else begin : g_next
      assign x_in = xi_q[i-1];
      assign y_in = yi_q[i-1];
      assign a_in = acc_q[i-1];
      assign z_in = zi_q[i-1];
      assign v_in = vi_q[i-1];
    end

    assign up = (y_in >= 0);

    if (i < ITER - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          xi_q[i] <= up ? (x_in + (y_in >>> i)) : (x_in - (y_in >>> i));
          yi_q[i] <= up ? (y_in - (x_in >>> i)) : (y_in + (x_in >>> i));
        end
      end
    end else begin : g_tail
      assign xi_q[i] = x_in;
      assign yi_q[i] = y_in;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        acc_q[i] <= up ? (a_in + ATAN_TURNS[i]) : (a_in - ATAN_TURNS[i]);
        zi_q[i]  <= z_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vi_q[i] <= 1'b0;
      end else if (ctl_i.en) begin
        vi_q[i] <= v_in;
      end
    end
  end

  // Round the turn to 16 bits; a zero vector gives angle zero
  assign rnd   = acc_q[ITER-1] + 32'h8000;
  assign ang_o = zi_q[ITER-1] ? 16'h0 : rnd[31:16];
  assign vld_o = vi_q[ITER-1];

endmodule

[rtl/texture_coordinate_generator_top.sv]
// Items pass the transform, squares, square root and angle units, then the output buffer.
// Throughput: one item per cycle; the pipeline holds as a whole only when the
// two-entry output buffer is full and not read.
// Reset: asynchronous active low; clears all valid flags, sets mode to none
// and the matrix to identity. No clearing pass is needed.
module texture_coordinate_generator_top import tcg_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CLAT = 3 + CORDIC_ITERATIONS;

  typedef struct packed {
    logic signed [32:0] ux;
    logic signed [32:0] uy;
    logic signed [31:0] y;
    logic signed [31:0] pu;
    logic signed [31:0] pv;
    logic               last;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] pu;
    logic signed [31:0] pv;
    logic signed [31:0] dv;
    logic               last;
  } an_side_t;

  logic [2:0]  mode_q;
  logic [63:0] pair_q [6];
  logic [2:0]  reg_idx;
  logic        en;

  // Configuration writes and reads
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      pair_q[0] <= 64'h0001_0000_0000_0000;
      pair_q[1] <= 64'h0;
      pair_q[2] <= 64'h0001_0000_0000_0000;
      pair_q[3] <= 64'h0;
      pair_q[4] <= 64'h0001_0000_0000_0000;
      pair_q[5] <= 64'h0;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == REG_MODE) begin
        mode_q <= pwdata[2:0];
      end else if (reg_idx >= REG_PAIR0 && reg_idx <= REG_PAIR5) begin
        pair_q[reg_idx - REG_PAIR0] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE) begin
      prdata = {61'b0, mode_q};
    end else if (reg_idx >= REG_PAIR0 && reg_idx <= REG_PAIR5) begin
      prdata = pair_q[reg_idx - REG_PAIR0];
    end
  end

  // Transform stages
  logic               xf_vld, xf_last;
  logic signed [31:0] xf_x, xf_y, xf_z;

  tcg_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, vld: in_valid_i}),
    .pos_x_i (in_item_i.pos_x),
    .pos_y_i (in_item_i.pos_y),
    .pos_z_i (in_item_i.pos_z),
    .last_i  (in_item_i.last_vertex),
    .pair_i  (pair_q),
    .vld_o   (xf_vld),
    .last_o  (xf_last),
    .x_o     (xf_x),
    .y_o     (xf_y),
    .z_o     (xf_z)
  );

  // Prepare squares, angle vector and plane coordinates
  logic signed [31:0] sec;
  logic signed [32:0] pu_sum, pv_sum;
  logic signed [63:0] sqa_q, sqb_q;
  logic [63:0]        sq_q;
  sq_side_t           side_p_q, side_s_q;
  logic               vp_q, vs_q;

  assign sec    = (mode_q == MODE_DISC) ? xf_y : xf_z;
  assign pu_sum = 33'(xf_x) + 33'sh10000;
  assign pv_sum = 33'(xf_y) + 33'sh10000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqa_q         <= xf_x * xf_x;
      sqb_q         <= sec * sec;
      side_p_q.ux   <= 33'(xf_x);
      side_p_q.uy   <= -33'(sec);
      side_p_q.y    <= xf_y;
      side_p_q.pu   <= pu_sum[32:1];
      side_p_q.pv   <= pv_sum[32:1];
      side_p_q.last <= xf_last;
      sq_q          <= sqa_q + sqb_q;
      side_s_q      <= side_p_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vs_q <= 1'b0;
    end else if (en) begin
      vp_q <= xf_vld;
      vs_q <= vp_q;
    end
  end

  // Square root with side data delayed alongside
  logic        sr_vld;
  logic [31:0] root;
  sq_side_t    sd_q [SQRT_STAGES];

  tcg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: vs_q}),
    .n_i    (sq_q),
    .vld_o  (sr_vld),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= side_s_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Two angle units in parallel: azimuth and polar angle
  logic        ca_vld;
  logic [15:0] ang_u, ang_v;
  an_side_t    an_in;
  an_side_t    cd_q [CLAT];

  tcg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_u (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: sr_vld}),
    .py_i   (34'(sd_q[SQRT_STAGES-1].uy)),
    .px_i   (34'(sd_q[SQRT_STAGES-1].ux)),
    .vld_o  (ca_vld),
    .ang_o  (ang_u)
  );

  tcg_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: sr_vld}),
    .py_i   ({2'b00, root}),
    .px_i   (34'(sd_q[SQRT_STAGES-1].y)),
    .vld_o  (),
    .ang_o  (ang_v)
  );

  assign an_in.pu   = sd_q[SQRT_STAGES-1].pu;
  assign an_in.pv   = sd_q[SQRT_STAGES-1].pv;
  assign an_in.dv   = root[31] ? 32'sh7FFFFFFF : $signed(root);
  assign an_in.last = sd_q[SQRT_STAGES-1].last;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cd_q[0] <= an_in;
      for (int k = 1; k < CLAT; k++) begin
        cd_q[k] <= cd_q[k-1];
      end
    end
  end

  // Select the result by mapping mode
  logic [15:0] pol;
  out_item_t   res;

  always_comb begin
    if (ang_v >= 16'hC000) begin
      pol = 16'h0;
    end else if (ang_v > 16'h8000) begin
      pol = 16'h8000;
    end else begin
      pol = ang_v;
    end
  end

  always_comb begin
    res.last_out = cd_q[CLAT-1].last;
    unique case (mode_q)
      MODE_PLANE: begin
        res.tex_u = cd_q[CLAT-1].pu;
        res.tex_v = cd_q[CLAT-1].pv;
      end
      MODE_SPHERE: begin
        res.tex_u = {16'h0, ang_u};
        res.tex_v = 32'sh10000 - {15'h0, pol, 1'b0};
      end
      MODE_CYLINDER: begin
        res.tex_u = {16'h0, ang_u};
        res.tex_v = cd_q[CLAT-1].pv;
      end
      MODE_DISC: begin
        res.tex_u = {16'h0, ang_u};
        res.tex_v = cd_q[CLAT-1].dv;
      end
      default: begin
        res.tex_u = '0;
        res.tex_v = '0;
      end
    endcase
  end

  // Two-entry output buffer parts the pipeline from the consumer
  out_item_t buf_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic      push, pop;

  assign en          = (cnt_q != 2'd2) || out_ready_i;
  assign in_ready_o  = en;
  assign push        = en && ca_vld;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[bench/tb.sv]
// Self-checking testbench for the texture coordinate generator top level.
module tb;
  import tcg_pkg::*;

  localparam int ITERS = 16;
  localparam int LATENCY = 41 + ITERS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  texture_coordinate_generator_top #(.CORDIC_ITERATIONS(ITERS)) dut (.*);

  // Clock and a single reset pulse
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the register file
  logic [2:0]  cfg_mode;
  logic [63:0] cfg_pair [6];

  in_item_t  vertex_q [$];
  out_item_t texcoord_q [$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;
  int        send_gap = 0;
  int        recv_stall = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Coefficient k: m00 m01 m02 m10 m11 m12 m20 m21 m22 tx ty tz
  function automatic longint coef(int k);
    logic [63:0] p;
    logic [31:0] h;
    p = cfg_pair[k >> 1];
    h = (k & 1) ? p[31:0] : p[63:32];
    return longint'($signed(h));
  endfunction

  function automatic longint affine_row(longint c0, longint a, longint c1, longint b,
                                        longint c2, longint c, longint t);
    longint p [3];
    longint hi;
    longint unsigned lo;
    p[0] = c0 * a;
    p[1] = c1 * b;
    p[2] = c2 * c;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      hi += p[i] >>> 16;
      lo += longint'(p[i]) & 64'hFFFF;
    end
    return sat32(hi + longint'(lo >> 16) + t);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Binary angle of (rx, ry) by CORDIC vectoring, full turn = 65536
  function automatic longint turn_angle(longint ry, longint rx);
    logic [31:0] acc;
    longint m, nx, ny, ay;
    acc = '0;
    if (rx == 0 && ry == 0) return 0;
    if (rx < 0) begin
      rx = -rx;
      ry = -ry;
      acc = 32'h8000_0000;
    end
    ay = (ry < 0) ? -ry : ry;
    m = (rx > ay) ? rx : ay;
    while (m < (64'sd1 <<< 39)) begin
      m *= 2;
      rx *= 2;
      ry *= 2;
    end
    for (int i = 0; i < ITERS && i < 24; i++) begin
      if (ry >= 0) begin
        nx = rx + (ry >>> i);
        ny = ry - (rx >>> i);
        acc += ATAN_TURNS[i];
      end else begin
        nx = rx - (ry >>> i);
        ny = ry + (rx >>> i);
        acc -= ATAN_TURNS[i];
      end
      rx = nx;
      ry = ny;
    end
    acc += 32'h8000;
    return longint'(acc[31:16]);
  endfunction

  function automatic out_item_t texcoords(in_item_t vin);
    longint px, py, pz, x, y, z, u, v, a;
    longint unsigned sq;
    out_item_t r;
    px = vin.pos_x;
    py = vin.pos_y;
    pz = vin.pos_z;
    x = affine_row(coef(0), px, coef(3), py, coef(6), pz, coef(9));
    y = affine_row(coef(1), px, coef(4), py, coef(7), pz, coef(10));
    z = affine_row(coef(2), px, coef(5), py, coef(8), pz, coef(11));
    u = 0;
    v = 0;
    case (cfg_mode)
      MODE_PLANE: begin
        u = (x + 64'sh10000) >>> 1;
        v = (y + 64'sh10000) >>> 1;
      end
      MODE_SPHERE: begin
        u = turn_angle(-z, x);
        sq = longint'(x * x) + longint'(z * z);
        a = turn_angle(longint'(root64(sq)), y);
        // Polar overshoot folds back into the half turn
        if (a >= 64'shC000) a = 0;
        else if (a > 64'sh8000) a = 64'sh8000;
        v = 64'sh10000 - 2 * a;
      end
      MODE_CYLINDER: begin
        u = turn_angle(-z, x);
        v = (y + 64'sh10000) >>> 1;
      end
      MODE_DISC: begin
        u = turn_angle(-y, x);
        sq = longint'(x * x) + longint'(y * y);
        v = sat32(longint'(root64(sq)));
      end
      default: ;
    endcase
    r.tex_u = u[31:0];
    r.tex_v = v[31:0];
    r.last_out = vin.last_vertex;
    return r;
  endfunction

  // Driver: hold each item until accepted, then idle for a drawn gap
  always @(posedge clk_i) begin
    logic nxt_valid;
    int   nxt_gap;
    nxt_valid = in_valid_i;
    nxt_gap = send_gap;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        texcoord_q.push_back(texcoords(in_item_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (vertex_q.size() > 0) begin
          in_item_i <= vertex_q.pop_front();
          nxt_valid = 1'b1;
          nxt_gap = no_idle ? 0 : $urandom_range(0, 7);
        end
      end
    end
    in_valid_i <= nxt_valid;
    send_gap <= nxt_gap;
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always @(posedge clk_i) begin
    out_item_t want;
    int        nxt_stall;
    nxt_stall = recv_stall;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (texcoord_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result u=%h v=%h last=%b",
                                         out_item_o.tex_u, out_item_o.tex_v,
                                         out_item_o.last_out);
        end else begin
          want = texcoord_q.pop_front();
          if (out_item_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected u=%h v=%h last=%b, got u=%h v=%h last=%b",
                       want.tex_u, want.tex_v, want.last_out, out_item_o.tex_u,
                       out_item_o.tex_v, out_item_o.last_out);
          end
        end
        nxt_stall = no_idle ? 0 : $urandom_range(0, 7);
      end else if (nxt_stall > 0) begin
        nxt_stall--;
      end
    end
    out_ready_i <= rst_ni && (nxt_stall == 0);
    recv_stall <= nxt_stall;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx * 8);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODE) cfg_mode = val[2:0];
    else cfg_pair[idx - REG_PAIR0] = val;
  endtask

  // Wait until the pipeline has drained; sample between edges so queues and
  // valid have settled
  task automatic drain();
    while (vertex_q.size() != 0 || in_valid_i || texcoord_q.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return '0;
      4: return 32'h0001_0000;
      5: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic last);
    in_item_t t;
    t.pos_x = x;
    t.pos_y = y;
    t.pos_z = z;
    t.last_vertex = last;
    return t;
  endfunction

  task automatic load_identity();
    reg_write(REG_PAIR0,           64'h0001_0000_0000_0000);
    reg_write(3'(REG_PAIR0 + 1), 64'h0);
    reg_write(3'(REG_PAIR0 + 2), 64'h0001_0000_0000_0000);
    reg_write(3'(REG_PAIR0 + 3), 64'h0);
    reg_write(3'(REG_PAIR0 + 4), 64'h0001_0000_0000_0000);
    reg_write(3'(REG_PAIR0 + 5), 64'h0);
  endtask

  initial begin
    logic [2:0] modes [8];
    logic [2:0] m;
    cfg_mode = MODE_NONE;
    cfg_pair = '{64'h0001_0000_0000_0000, 64'h0, 64'h0001_0000_0000_0000,
                 64'h0, 64'h0001_0000_0000_0000, 64'h0};
    modes = '{MODE_NONE, MODE_PLANE, MODE_SPHERE, MODE_CYLINDER, MODE_DISC,
              3'(MODE_DISC + 1), 3'(MODE_DISC + 2), 3'(MODE_DISC + 3)};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, zero vector and axes under every defined mode
    for (int i = 0; i < 5; i++) begin
      reg_write(REG_MODE, 64'(modes[i]));
      vertex_q.push_back(vertex('0, '0, '0, 1'b0));
      vertex_q.push_back(vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      vertex_q.push_back(vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
      vertex_q.push_back(vertex(32'hFFFF_0000, 32'h0001_0000, '0, 1'b1));
      vertex_q.push_back(vertex('0, 32'hFFFF_0000, 32'h0001_0000, 1'b0));
      drain();
    end

    // Random phases: mode codes in turn, with identity, extreme or random matrices
    for (int ph = 0; ph < 12; ph++) begin
      m = modes[ph % 8];
      reg_write(REG_MODE, 64'(m));
      if (ph % 4 == 0) begin
        load_identity();
      end else if (ph == 3) begin
        for (int k = 0; k < 6; k++)
          reg_write(3'(REG_PAIR0 + k), 64'h7FFF_FFFF_8000_0000);
      end else if (ph == 7) begin
        for (int k = 0; k < 6; k++)
          reg_write(3'(REG_PAIR0 + k), 64'hFFFF_FFFF_FFFF_FFFF);
      end else begin
        for (int k = 0; k < 6; k++)
          reg_write(3'(REG_PAIR0 + k), {rand_coef(), rand_coef()});
      end
      no_idle = (ph % 5 == 2);
      for (int n = 0; n < 94; n++)
        vertex_q.push_back(vertex(rand_coord(), rand_coord(), rand_coord(),
                                  1'($urandom_range(0, 1))));
      drain();
    end

    if (mismatches == 0) begin
      $display("** texture_coordinate_generator_top: PASSED **");
    end else begin
      $display("** texture_coordinate_generator_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("** texture_coordinate_generator_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/tcg_pkg.sv
rtl/tcg_xform.sv
rtl/tcg_isqrt.sv
rtl/tcg_cordic.sv
rtl/texture_coordinate_generator_top.sv
bench/tb.sv
